// ----- rtl/core/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Field widths, command and status codes, sequencer states and the
// write-control bundle passed from the sequencer to the frame table.
// ----------------------------------------------------------------------------
package pfa_pkg;

	// Request and result field widths.
	localparam int CMD_W   = 3;
	localparam int FRAME_W = 5;
	localparam int OWNER_W = 8;
	localparam int VPAGE_W = 16;
	localparam int STAMP_W = 32;

	// Request commands; the remaining codes are treated as no-ops.
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 3'd0,
		CMD_FORCE = 3'd1,
		CMD_FREE  = 3'd2,
		CMD_TEST  = 3'd3,
		CMD_TOUCH = 3'd4
	} cmd_t;

	// Result status codes.
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// What a table scan is looking for.
	typedef enum logic {
		SCAN_FREE = 1'b0,
		SCAN_LRU  = 1'b1
	} scan_mode_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_DRAIN,
		ST_INSTALL,
		ST_FETCH,
		ST_EVICT,
		ST_LOOKUP,
		ST_CHECK,
		ST_RESP
	} state_t;

	// Write controls for the frame table.
	typedef struct packed {
		logic used_we;   // write the used bit
		logic used_d;    // new used bit
		logic info_we;   // write owner, page and stamp
		logic stamp_we;  // write the stamp alone
	} tbl_wr_t;

endpackage : pfa_pkg
`default_nettype wire

// ----- rtl/core/pfa_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_table: per-frame storage
// Single-port memories for the used bit, owner, virtual page and last-use
// stamp of every frame. One address per cycle, registered read data.
// ----------------------------------------------------------------------------
module pfa_table import pfa_pkg::*; #(
	parameter int FRAMES = 32
) (
	input  wire logic                       clk,
	input  wire logic [$clog2(FRAMES)-1:0]  addr,
	input  wire logic                       rd_en,
	input  wire tbl_wr_t                    wr,
	input  wire logic [OWNER_W-1:0]         owner_d,
	input  wire logic [VPAGE_W-1:0]         vpage_d,
	input  wire logic [STAMP_W-1:0]         stamp_d,
	output logic                            rd_used,
	output logic [OWNER_W-1:0]              rd_owner,
	output logic [VPAGE_W-1:0]              rd_vpage,
	output logic [STAMP_W-1:0]              rd_stamp
);

	logic               used_mem  [FRAMES];
	logic [OWNER_W-1:0] owner_mem [FRAMES];
	logic [VPAGE_W-1:0] vpage_mem [FRAMES];
	logic [STAMP_W-1:0] stamp_mem [FRAMES];

	logic               rd_used_q;
	logic [OWNER_W-1:0] rd_owner_q;
	logic [VPAGE_W-1:0] rd_vpage_q;
	logic [STAMP_W-1:0] rd_stamp_q;

	// Writes; the stamp is written by a full install or by itself.
	always_ff @(posedge clk) begin
		if (wr.used_we) begin
			used_mem[addr] <= wr.used_d;
		end
		if (wr.info_we) begin
			owner_mem[addr] <= owner_d;
			vpage_mem[addr] <= vpage_d;
		end
		if (wr.info_we || wr.stamp_we) begin
			stamp_mem[addr] <= stamp_d;
		end
	end

	// Registered reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_used_q  <= used_mem[addr];
			rd_owner_q <= owner_mem[addr];
			rd_vpage_q <= vpage_mem[addr];
			rd_stamp_q <= stamp_mem[addr];
		end
	end

	assign rd_used  = rd_used_q;
	assign rd_owner = rd_owner_q;
	assign rd_vpage = rd_vpage_q;
	assign rd_stamp = rd_stamp_q;

endmodule : pfa_table
`default_nettype wire

// ----- rtl/core/pfa_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_scan: shared search unit
// Sees one table entry per cycle in ascending frame order and keeps the
// first free frame, or the frame with the smallest stamp (first one wins
// on ties), using a single stamp comparator.
// ----------------------------------------------------------------------------
module pfa_scan import pfa_pkg::*; #(
	parameter int FRAMES = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clr,
	input  wire scan_mode_t                 mode,
	input  wire logic                       vld,
	input  wire logic [$clog2(FRAMES)-1:0]  idx,
	input  wire logic                       used,
	input  wire logic [STAMP_W-1:0]         stamp_i,
	output logic                            found,
	output logic [$clog2(FRAMES)-1:0]       best_idx
);

	localparam int FW = $clog2(FRAMES);

	logic               found_q;
	logic [FW-1:0]      best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               older;
	logic               take;

	// The one comparator: is this entry older than the best so far?
	assign older = stamp_i < best_stamp_q;

	// Free search keeps the first free entry; LRU search keeps the first
	// entry and then any strictly older one.
	always_comb begin
		case (mode)
			SCAN_FREE: take = vld && !used && !found_q;
			SCAN_LRU:  take = vld && (!found_q || older);
			default:   take = 1'b0;
		endcase
	end

	// Found flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Best candidate.
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx;
			best_stamp_q <= stamp_i;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;

endmodule : pfa_scan
`default_nettype wire

// ----- rtl/core/page_frame_allocator_lru.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator_lru: physical frame allocator with LRU replacement
// Request channel (in_valid/in_ready) carries a command, a frame number and
// the owner, page and stamp to record. Result channel (out_valid/out_ready)
// returns one result per request. Requests are taken one at a time.
// Allocations walk the frame table one entry per cycle through its single
// read port into one shared stamp comparator; a force alloc on a full table
// then reads and overwrites the frame with the oldest stamp. An alloc on a
// full table, a touch, an unknown command and a free or test of an
// out-of-range frame are answered without a walk.
// After reset the used bits are cleared one frame per cycle, with in_ready
// low. A finished result sits in an output register; the next request is
// taken while it waits, but a second result waits in the sequencer until
// out_ready frees the register.
// ----------------------------------------------------------------------------
module page_frame_allocator_lru import pfa_pkg::*; #(
	parameter int FRAMES = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Request channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CMD_W-1:0]   command,
	input  wire logic [FRAME_W-1:0] frame,
	input  wire logic [OWNER_W-1:0] owner_id,
	input  wire logic [VPAGE_W-1:0] virtual_page,
	input  wire logic [STAMP_W-1:0] stamp,
	// Result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    status,
	output logic [FRAME_W-1:0]      granted_frame,
	output logic                    is_allocated,
	output logic                    evicted,
	output logic [OWNER_W-1:0]      victim_owner,
	output logic [VPAGE_W-1:0]      victim_page
);

	localparam int FW   = $clog2(FRAMES);
	localparam int CNTW = $clog2(FRAMES + 1);
	localparam int CW   = (FW > FRAME_W ? FW : FRAME_W) + 1;

	// Sequencer state and request registers.
	state_t             state_q, state_d;
	cmd_t               cmd_q;
	logic [FRAME_W-1:0] frame_q;
	logic [OWNER_W-1:0] owner_q;
	logic [VPAGE_W-1:0] vpage_q;
	logic [STAMP_W-1:0] stamp_q;
	scan_mode_t         mode_q;
	logic [FW-1:0]      ptr_q;
	logic [CNTW-1:0]    used_count_q;

	// Read pipeline tag for the scan.
	logic               vld_s1;
	logic [FW-1:0]      idx_s1;

	// Pending result.
	logic               res_status_q;
	logic [FRAME_W-1:0] res_grant_q;
	logic               res_alloc_q;
	logic               res_evict_q;
	logic [OWNER_W-1:0] res_owner_q;
	logic [VPAGE_W-1:0] res_page_q;

	// Output register.
	logic               out_valid_q;
	logic               status_q;
	logic [FRAME_W-1:0] granted_q;
	logic               is_alloc_q;
	logic               evicted_q;
	logic [OWNER_W-1:0] victim_owner_q;
	logic [VPAGE_W-1:0] victim_page_q;

	// Table and scan connections.
	logic [FW-1:0]      tbl_addr;
	logic               tbl_rd_en;
	tbl_wr_t            tbl_wr;
	logic               rd_used;
	logic [OWNER_W-1:0] rd_owner;
	logic [VPAGE_W-1:0] rd_vpage;
	logic [STAMP_W-1:0] rd_stamp;
	logic               scan_clr;
	logic               scan_found;
	logic [FW-1:0]      best_idx;

	// Combinational controls.
	logic               accept;
	logic               frame_ok;
	logic [FW-1:0]      frame_idx;
	logic               table_full;
	logic               ptr_last;
	logic               cnt_inc;
	logic               cnt_dec;
	logic               out_load;

	assign accept     = in_valid && in_ready;
	assign frame_ok   = CW'(frame_q) < CW'(FRAMES);
	assign frame_idx  = FW'(frame_q);
	assign table_full = used_count_q == CNTW'(FRAMES);
	assign ptr_last   = ptr_q == FW'(FRAMES - 1);
	assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_ready);
	assign in_ready   = state_q == ST_IDLE;

	// Frame table.
	pfa_table #(
		.FRAMES(FRAMES)
	) u_table (
		.clk      (clk),
		.addr     (tbl_addr),
		.rd_en    (tbl_rd_en),
		.wr       (tbl_wr),
		.owner_d  (owner_q),
		.vpage_d  (vpage_q),
		.stamp_d  (stamp_q),
		.rd_used  (rd_used),
		.rd_owner (rd_owner),
		.rd_vpage (rd_vpage),
		.rd_stamp (rd_stamp)
	);

	// Search unit fed by the read pipeline.
	pfa_scan #(
		.FRAMES(FRAMES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (scan_clr),
		.mode     (mode_q),
		.vld      (vld_s1),
		.idx      (idx_s1),
		.used     (rd_used),
		.stamp_i  (rd_stamp),
		.found    (scan_found),
		.best_idx (best_idx)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, table access and counter controls.
	always_comb begin
		state_d   = state_q;
		tbl_addr  = ptr_q;
		tbl_rd_en = 1'b0;
		tbl_wr    = '0;
		scan_clr  = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				tbl_wr.used_we = 1'b1;
				tbl_wr.used_d  = 1'b0;
				if (ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				scan_clr = 1'b1;
				case (cmd_q)
					CMD_ALLOC, CMD_FORCE: begin
						if (!table_full || cmd_q == CMD_FORCE) begin
							state_d = ST_SCAN;
						end else begin
							state_d = ST_RESP;
						end
					end
					CMD_FREE, CMD_TEST: begin
						state_d = frame_ok ? ST_LOOKUP : ST_RESP;
					end
					CMD_TOUCH: begin
						tbl_addr        = frame_idx;
						tbl_wr.stamp_we = frame_ok;
						state_d         = ST_RESP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCAN: begin
				tbl_rd_en = 1'b1;
				if (ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (mode_q == SCAN_FREE) ? ST_INSTALL : ST_FETCH;
			end
			ST_INSTALL: begin
				tbl_addr       = best_idx;
				tbl_wr.used_we = 1'b1;
				tbl_wr.used_d  = 1'b1;
				tbl_wr.info_we = 1'b1;
				cnt_inc        = 1'b1;
				state_d        = ST_RESP;
			end
			ST_FETCH: begin
				tbl_addr  = best_idx;
				tbl_rd_en = 1'b1;
				state_d   = ST_EVICT;
			end
			ST_EVICT: begin
				tbl_addr       = best_idx;
				tbl_wr.info_we = 1'b1;
				state_d        = ST_RESP;
			end
			ST_LOOKUP: begin
				tbl_addr  = frame_idx;
				tbl_rd_en = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				tbl_addr = frame_idx;
				if (cmd_q == CMD_FREE && rd_used) begin
					tbl_wr.used_we = 1'b1;
					tbl_wr.used_d  = 1'b0;
					cnt_dec        = used_count_q != '0;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture; payload only.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(command);
			frame_q <= frame;
			owner_q <= owner_id;
			vpage_q <= virtual_page;
			stamp_q <= stamp;
		end
	end

	// Scan mode: a force alloc on a full table looks for the oldest stamp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= SCAN_FREE;
		end else if (state_q == ST_DISPATCH) begin
			mode_q <= (cmd_q == CMD_FORCE && table_full) ? SCAN_LRU : SCAN_FREE;
		end
	end

	// Frame pointer for the clearing pass and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
			ptr_q <= ptr_last ? '0 : ptr_q + FW'(1);
		end else if (accept) begin
			ptr_q <= '0;
		end
	end

	// Read tag: which frame the table output belongs to during a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= state_q == ST_SCAN;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
	end

	// Used frame count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_count_q <= '0;
		end else if (cnt_inc) begin
			used_count_q <= used_count_q + CNTW'(1);
		end else if (cnt_dec) begin
			used_count_q <= used_count_q - CNTW'(1);
		end
	end

	// Result fields, built up while the request is worked on.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_status_q <= STATUS_DONE;
				res_grant_q  <= '0;
				res_alloc_q  <= 1'b0;
				res_evict_q  <= 1'b0;
				res_owner_q  <= '0;
				res_page_q   <= '0;
			end
			ST_DISPATCH: begin
				if (cmd_q == CMD_ALLOC && table_full) begin
					res_status_q <= STATUS_FULL;
				end
			end
			ST_INSTALL: begin
				res_grant_q <= FRAME_W'(best_idx);
			end
			ST_EVICT: begin
				res_grant_q <= FRAME_W'(best_idx);
				res_evict_q <= 1'b1;
				res_owner_q <= rd_owner;
				res_page_q  <= rd_vpage;
			end
			ST_CHECK: begin
				if (cmd_q == CMD_TEST) begin
					res_alloc_q <= rd_used;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q       <= res_status_q;
			granted_q      <= res_grant_q;
			is_alloc_q     <= res_alloc_q;
			evicted_q      <= res_evict_q;
			victim_owner_q <= res_owner_q;
			victim_page_q  <= res_page_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_frame = granted_q;
	assign is_allocated  = is_alloc_q;
	assign evicted       = evicted_q;
	assign victim_owner  = victim_owner_q;
	assign victim_page   = victim_page_q;

	// The count never passes the number of frames.
	assert property (@(posedge clk) disable iff (!arst_n)
		used_count_q <= CNTW'(FRAMES))
		else $error("used frame count exceeds the number of frames");

	// The count moves by at most one per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (used_count_q == $past(used_count_q)) ||
			(used_count_q == $past(used_count_q) + CNTW'(1)) ||
			(used_count_q == $past(used_count_q) - CNTW'(1)))
		else $error("used frame count jumped");

	// A free-frame install always follows a scan that found a free frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSTALL) |-> scan_found)
		else $error("install without a free frame");

	// An eviction happens only after a scan of a full table.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> (table_full && mode_q == SCAN_LRU))
		else $error("eviction while a free frame exists");

	// New results are loaded only from the response state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result appeared outside the response state");

endmodule : page_frame_allocator_lru
`default_nettype wire

// ----- verif/page_frame_allocator_lru_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_lru_test: self-checking bench for the frame allocator
// A scoreboard keeps its own copy of the frame table. It predicts every
// result: lowest-free grants, full reports, least-recently-used eviction,
// free, test and touch. Random request phases fill and drain the table, and
// both handshakes stall at random.
// ----------------------------------------------------------------------------
module page_frame_allocator_lru_test;
	import pfa_pkg::*;

	localparam int FRAMES          = 32;
	localparam int CMD_LAST        = (1 << CMD_W) - 1;
	localparam int IDLE_PCT        = 12;
	localparam int RANDOM_REQUESTS = 1550;
	localparam int SETTLE_CYCLES   = 2 * FRAMES + 12;
	localparam int QUIET_FIRST     = 600;
	localparam int QUIET_LAST      = 900;
	localparam int MAX_PRINTED     = 40;

	// One result as it leaves the block.
	typedef struct packed {
		logic               status;
		logic [FRAME_W-1:0] granted_frame;
		logic               is_allocated;
		logic               evicted;
		logic [OWNER_W-1:0] victim_owner;
		logic [VPAGE_W-1:0] victim_page;
	} frame_result_t;

	// Command mixes of the random phases.
	typedef enum int {
		FILL_HEAVY,
		DRAIN_HEAVY,
		BALANCED_MIX
	} phase_mix_t;

	// Frame table copy, expected results and the mismatch count.
	class frame_scoreboard;
		bit                 used[FRAMES];
		logic [OWNER_W-1:0] owner_of[FRAMES];
		logic [VPAGE_W-1:0] vpage_of[FRAMES];
		logic [STAMP_W-1:0] stamp_of[FRAMES];
		frame_result_t      expected_q[$];
		int                 errors;

		function new();
			for (int i = 0; i < FRAMES; i++) begin
				used[i] = 1'b0;
				owner_of[i] = '0;
				vpage_of[i] = '0;
				stamp_of[i] = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void install(int f, logic [OWNER_W-1:0] owner, logic [VPAGE_W-1:0] page,
				logic [STAMP_W-1:0] stmp);
			owner_of[f] = owner;
			vpage_of[f] = page;
			stamp_of[f] = stmp;
		endfunction

		// Applies one accepted request to the table and queues its result.
		function void note_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frm,
				logic [OWNER_W-1:0] owner, logic [VPAGE_W-1:0] page,
				logic [STAMP_W-1:0] stmp);
			frame_result_t r;
			int            pick;
			r = '0;
			r.status = STATUS_DONE;
			pick = FRAMES;
			case (cmd)
			CMD_ALLOC, CMD_FORCE: begin
				for (int i = FRAMES - 1; i >= 0; i--)
					if (!used[i])
						pick = i;
				if (pick < FRAMES) begin
					used[pick] = 1'b1;
					install(pick, owner, page, stmp);
					r.granted_frame = pick[FRAME_W-1:0];
				end else if (cmd == CMD_ALLOC) begin
					r.status = STATUS_FULL;
				end else begin
					// Table is full: the oldest stamp loses, lowest index on ties.
					pick = 0;
					for (int i = 1; i < FRAMES; i++)
						if (stamp_of[i] < stamp_of[pick])
							pick = i;
					r.evicted = 1'b1;
					r.victim_owner = owner_of[pick];
					r.victim_page = vpage_of[pick];
					install(pick, owner, page, stmp);
					r.granted_frame = pick[FRAME_W-1:0];
				end
			end
			CMD_FREE: begin
				used[frm] = 1'b0;
			end
			CMD_TEST: begin
				r.is_allocated = used[frm];
			end
			CMD_TOUCH: begin
				// The stamp is written even when the frame is free.
				stamp_of[frm] = stmp;
			end
			default: begin
			end
			endcase
			expected_q.push_back(r);
		endfunction

		task report(string what, longint unsigned got_v, longint unsigned exp_v);
			if (errors < MAX_PRINTED)
				$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got_v,
					exp_v);
			errors++;
		endtask

		// Compares one result with the oldest expectation, field by field.
		task check_result(frame_result_t got);
			frame_result_t exp;
			if (expected_q.size() == 0) begin
				report("result with no request waiting", got, 0);
			end else begin
				exp = expected_q.pop_front();
				if (got.status !== exp.status)
					report("status", got.status, exp.status);
				if (got.granted_frame !== exp.granted_frame)
					report("granted_frame", got.granted_frame, exp.granted_frame);
				if (got.is_allocated !== exp.is_allocated)
					report("is_allocated", got.is_allocated, exp.is_allocated);
				if (got.evicted !== exp.evicted)
					report("evicted", got.evicted, exp.evicted);
				if (got.victim_owner !== exp.victim_owner)
					report("victim_owner", got.victim_owner, exp.victim_owner);
				if (got.victim_page !== exp.victim_page)
					report("victim_page", got.victim_page, exp.victim_page);
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [CMD_W-1:0]   command;
	logic [FRAME_W-1:0] frame;
	logic [OWNER_W-1:0] owner_id;
	logic [VPAGE_W-1:0] virtual_page;
	logic [STAMP_W-1:0] stamp;
	logic               out_valid;
	logic               out_ready;
	logic               status;
	logic [FRAME_W-1:0] granted_frame;
	logic               is_allocated;
	logic               evicted;
	logic [OWNER_W-1:0] victim_owner;
	logic [VPAGE_W-1:0] victim_page;

	bit                 quiet;
	frame_scoreboard    sb;

	page_frame_allocator_lru #(
		.FRAMES(FRAMES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.frame(frame),
		.owner_id(owner_id),
		.virtual_page(virtual_page),
		.stamp(stamp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_frame(granted_frame),
		.is_allocated(is_allocated),
		.evicted(evicted),
		.victim_owner(victim_owner),
		.victim_page(victim_page)
	);

	always #2 clk = ~clk;

	// Result side: check each accepted result, then stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({status, granted_frame, is_allocated, evicted, victim_owner,
				victim_page});
		out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Drives one request and waits until the block takes it.
	task send_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frm,
			logic [OWNER_W-1:0] owner, logic [VPAGE_W-1:0] page, logic [STAMP_W-1:0] stmp);
		if (!quiet) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		command <= cmd;
		frame <= frm;
		owner_id <= owner;
		virtual_page <= page;
		stamp <= stmp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(cmd, frm, owner, page, stmp);
	endtask

	// Drops valid and holds off until every queued result has come back.
	task drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Stimulus: reset, a directed opening, then random phases.
	initial begin
		logic [CMD_W-1:0]   cmd;
		logic [STAMP_W-1:0] stmp;
		phase_mix_t         mix;
		int                 counted;
		int                 phase_no;
		int                 phase_len;
		int                 roll;
		int                 t_alloc;
		int                 t_force;
		int                 t_free;
		int                 t_test;
		int                 t_touch;

		sb = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = CMD_ALLOC;
		frame = '0;
		owner_id = '0;
		virtual_page = '0;
		stamp = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: field extremes, every command, the no-op cases.
		send_request(CMD_TEST, 0, 0, 0, 0);
		send_request(CMD_ALLOC, 0, '0, '0, '0);
		send_request(CMD_ALLOC, '1, '1, '1, '1);
		send_request(CMD_TEST, 0, 0, 0, 0);
		send_request(CMD_TEST, '1, 0, 0, 0);
		send_request(CMD_TOUCH, '1, 0, 0, 32'd5);
		send_request(CMD_TOUCH, 0, 0, 0, '1);
		send_request(CMD_FREE, 0, 0, 0, 0);
		send_request(CMD_FREE, 0, 0, 0, 0);
		send_request(CMD_TEST, 0, 0, 0, 0);
		send_request(CMD_FORCE, 0, 8'h5a, 16'ha5c3, 32'd7);
		send_request(CMD_TOUCH, 1, 0, 0, '0);
		for (int c = CMD_TOUCH + 1; c <= CMD_LAST; c++)
			send_request(CMD_W'(c), '1, '1, '1, '1);
		send_request(CMD_FREE, 1, 0, 0, 0);
		send_request(CMD_FREE, 0, 0, 0, 0);
		drain_results();

		// Random phases; the first one fills the table so that full cases come early.
		counted = 0;
		phase_no = 0;
		while (counted < RANDOM_REQUESTS) begin
			mix = (phase_no == 0) ? FILL_HEAVY : phase_mix_t'($urandom_range(0, 2));
			case (mix)
			FILL_HEAVY: begin
				t_alloc = 45; t_force = 70; t_free = 74; t_test = 86; t_touch = 98;
			end
			DRAIN_HEAVY: begin
				t_alloc = 15; t_force = 25; t_free = 70; t_test = 85; t_touch = 98;
			end
			default: begin
				t_alloc = 25; t_force = 45; t_free = 65; t_test = 80; t_touch = 98;
			end
			endcase
			phase_len = $urandom_range(40, 120);
			for (int n = 0; n < phase_len && counted < RANDOM_REQUESTS; n++) begin
				quiet = (counted >= QUIET_FIRST && counted < QUIET_LAST);
				roll = $urandom_range(0, 99);
				if (roll < t_alloc)
					cmd = CMD_ALLOC;
				else if (roll < t_force)
					cmd = CMD_FORCE;
				else if (roll < t_free)
					cmd = CMD_FREE;
				else if (roll < t_test)
					cmd = CMD_TEST;
				else if (roll < t_touch)
					cmd = CMD_TOUCH;
				else
					cmd = CMD_W'($urandom_range(CMD_TOUCH + 1, CMD_LAST));

				// Small stamps make eviction ties common; the rest cover every bit.
				roll = $urandom_range(0, 99);
				if (roll < 40)
					stmp = $urandom_range(0, 7);
				else if (roll < 80)
					stmp = $urandom;
				else if (roll < 90)
					stmp = '0;
				else
					stmp = '1;

				send_request(cmd, FRAME_W'($urandom_range(0, FRAMES - 1)),
					OWNER_W'($urandom_range(0, 255)),
					VPAGE_W'($urandom_range(0, 65535)), stmp);
				if (cmd <= CMD_TOUCH)
					counted++;
			end
			if (phase_no % 4 == 3)
				drain_results();
			phase_no++;
		end
		quiet = 1'b0;

		// Wind down: let every result arrive, then watch for strays.
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/pfa_pkg.sv
rtl/core/pfa_table.sv
rtl/core/pfa_scan.sv
rtl/core/page_frame_allocator_lru.sv
verif/page_frame_allocator_lru_test.sv
